### design/wcm_pkg.sv
// Package for the weighted covariance matrix unit.
// Holds sizes, the sequencer state type, register codes and shared structs.
// No dependencies.
package wcm_pkg;

    localparam int MAX_AXES    = 6;
    localparam int COORD_BITS  = 24;
    localparam int WEIGHT_BITS = 16;
    localparam int AX_BITS     = 3;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int NPAIRS      = MAX_AXES * MAX_AXES;
    localparam int IDX_BITS    = $clog2(NPAIRS);
    localparam int SUM_BITS    = 64;
    localparam int WT_BITS     = 48;
    localparam int OUT_BITS    = 48;
    localparam int FRAC_BITS   = 16;
    localparam int PROD_BITS   = 2 * DIFF_BITS;
    localparam int Q_BITS      = PROD_BITS - FRAC_BITS;
    localparam int TERM_BITS   = Q_BITS + WEIGHT_BITS;
    localparam int CNT_BITS    = $clog2(SUM_BITS);
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_BITS    = COORD_BITS;
    localparam int IN_BITS     = WEIGHT_BITS + MAX_AXES * COORD_BITS;
    localparam int OUT_TDATA_BITS = 56;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_AXIS_COUNT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MEAN_BASE  = 3'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_DRD,
        ST_DLD,
        ST_DRUN,
        ST_OUT,
        ST_CLR
    } t_state;

    // Write-back request from the multiply-accumulate unit to the sum store.
    typedef struct packed {
        logic                       vld;
        logic [IDX_BITS-1:0]        idx;
        logic signed [SUM_BITS-1:0] sum;
    } t_wb;

    // Place of pair (j,k) in the sum store.
    function automatic logic [IDX_BITS-1:0] pair_idx(input logic [AX_BITS-1:0] j,
                                                     input logic [AX_BITS-1:0] k);
        logic [IDX_BITS+AX_BITS-1:0] full;
        begin
            full = IDX_BITS'(j) * IDX_BITS'(MAX_AXES) + IDX_BITS'(k);
            pair_idx = full[IDX_BITS-1:0];
        end
    endfunction

endpackage

### design/wcm_mac.sv
// Shared multiply-accumulate unit: one pair term per cycle.
// Depends on wcm_pkg.
module wcm_mac (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_issue,
    input  logic [wcm_pkg::IDX_BITS-1:0]            i_idx,
    input  logic signed [wcm_pkg::DIFF_BITS-1:0]    i_dj,
    input  logic signed [wcm_pkg::DIFF_BITS-1:0]    i_dk,
    input  logic [wcm_pkg::WEIGHT_BITS-1:0]         i_weight,
    input  logic signed [wcm_pkg::SUM_BITS-1:0]     i_old,
    output wcm_pkg::t_wb                            o_wb
);
    import wcm_pkg::*;

    logic [DIFF_BITS-1:0]        magj, magk;
    logic [PROD_BITS-1:0]        r1_prod;
    logic                        r1_neg, r1_vld, r2_neg, r2_vld;
    logic [IDX_BITS-1:0]         r1_idx, r2_idx;
    logic [Q_BITS-1:0]           q;
    logic [TERM_BITS-1:0]        r2_term;
    logic signed [SUM_BITS-1:0]  r2_old;
    logic signed [SUM_BITS:0]    s_ext, t_ext, res;

    // Magnitudes of the two centered coordinates.
    assign magj = i_dj[DIFF_BITS-1] ? DIFF_BITS'(-i_dj) : DIFF_BITS'(i_dj);
    assign magk = i_dk[DIFF_BITS-1] ? DIFF_BITS'(-i_dk) : DIFF_BITS'(i_dk);

    // Fraction drop with rounding toward minus infinity for negative products.
    assign q = Q_BITS'(r1_prod[PROD_BITS-1:FRAC_BITS])
             + Q_BITS'(r1_neg && (r1_prod[FRAC_BITS-1:0] != '0));

    // Stage registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else begin
            r1_vld <= i_issue;
            r2_vld <= r1_vld;
        end
        r1_prod <= magj * magk;
        r1_neg  <= i_dj[DIFF_BITS-1] ^ i_dk[DIFF_BITS-1];
        r1_idx  <= i_idx;
        r2_term <= q * i_weight;
        r2_neg  <= r1_neg;
        r2_idx  <= r1_idx;
        r2_old  <= i_old;
    end

    // Saturating accumulate into the signed 64-bit range.
    assign s_ext = {r2_old[SUM_BITS-1], r2_old};
    assign t_ext = (SUM_BITS+1)'(r2_term);
    assign res   = r2_neg ? (s_ext - t_ext) : (s_ext + t_ext);

    always_comb begin
        o_wb.vld = r2_vld;
        o_wb.idx = r2_idx;
        if (res[SUM_BITS] != res[SUM_BITS-1]) begin
            o_wb.sum = res[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                     : {1'b0, {(SUM_BITS-1){1'b1}}};
        end else begin
            o_wb.sum = res[SUM_BITS-1:0];
        end
    end

endmodule

### design/wcm_div.sv
// Bit-serial restoring divider: signed 64-bit sum over unsigned 48-bit weight.
// Gives a saturated 48-bit quotient truncated toward zero. Depends on wcm_pkg.
module wcm_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [wcm_pkg::SUM_BITS-1:0]  i_num,
    input  logic [wcm_pkg::WT_BITS-1:0]          i_den,
    output logic                                 o_done,
    output logic [wcm_pkg::OUT_BITS-1:0]         o_quot
);
    import wcm_pkg::*;

    localparam logic [SUM_BITS-1:0] POS_LIM = SUM_BITS'(1) << (OUT_BITS - 1);

    logic                 r_busy, r_done, r_neg;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [SUM_BITS-1:0]  r_num;
    logic [WT_BITS-1:0]   r_rem;
    logic [WT_BITS-1:0]   r_den;
    logic [WT_BITS:0]     trial;
    logic                 fits;
    logic [SUM_BITS-1:0]  qclip;

    // One quotient bit per cycle; the remainder stays below a nonzero divisor.
    assign trial = {r_rem, r_num[SUM_BITS-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_BITS'(SUM_BITS - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_neg <= i_num[SUM_BITS-1];
            r_num <= i_num[SUM_BITS-1] ? SUM_BITS'(-i_num) : SUM_BITS'(i_num);
            r_rem <= '0;
            r_den <= i_den;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? WT_BITS'(trial - {1'b0, r_den}) : trial[WT_BITS-1:0];
            r_num <= {r_num[SUM_BITS-2:0], fits};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Saturate to the signed 48-bit output range.
    always_comb begin
        if (r_neg) begin
            qclip  = (r_num > POS_LIM) ? POS_LIM : r_num;
            o_quot = OUT_BITS'(-qclip);
        end else begin
            qclip  = (r_num > POS_LIM - 1'b1) ? (POS_LIM - 1'b1) : r_num;
            o_quot = qclip[OUT_BITS-1:0];
        end
    end

    assign o_done = r_done;

endmodule

### design/weighted_covariance_matrix_unit.sv
// Weighted covariance matrix unit: top level with sequencer and pair-sum store.
// A hit holds off the input after its request (n axes in use) while the sequencer issues
// its n*n multiply-accumulate terms and drains the pipeline, so a new hit waits for that.
// A last hit then gives n*n entries, each read from the store and divided by the
// one-bit-per-cycle divider (skipped when the weight total is zero), then a clear state.
// Synchronous active-low reset clears sums (per-entry valid bits) and the control and configuration registers.
module weighted_covariance_matrix_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // hit_weight[15:0], coord_0 .. coord_5 (24 bits each, from bit 16 up)
    input  logic [wcm_pkg::IN_BITS-1:0]              s_axis_tdata,
    input  logic                                     s_axis_tlast,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // row[2:0], col[5:3], cov_value[53:6], zero fill [55:54]
    output logic [wcm_pkg::OUT_TDATA_BITS-1:0]       m_axis_tdata,
    // zero_weight[0]
    output logic                                     m_axis_tuser,
    output logic                                     m_axis_tlast,
    input  logic                                     i_cfg_we,
    input  logic [wcm_pkg::CFG_IDX_BITS-1:0]         i_cfg_idx,
    input  logic [wcm_pkg::CFG_BITS-1:0]             i_cfg_data
);
    import wcm_pkg::*;

    localparam logic [WT_BITS-1:0] WT_MAX = '1;

    t_state                      r_state, n_state;
    logic [AX_BITS-1:0]          r_axis_count, eff_n, r_n;
    logic signed [COORD_BITS-1:0] r_mean [MAX_AXES];
    logic signed [DIFF_BITS-1:0] r_d [MAX_AXES];
    logic signed [DIFF_BITS-1:0] r_rot [MAX_AXES];
    logic [WEIGHT_BITS-1:0]      r_w;
    logic [WT_BITS-1:0]          r_wt;
    logic [WT_BITS:0]            wt_sum;
    logic                        r_last;
    logic [AX_BITS-1:0]          r_j, r_k;
    logic [1:0]                  r_dcnt;
    logic signed [SUM_BITS-1:0]  r_mem [NPAIRS];
    logic [NPAIRS-1:0]           r_vld;
    logic signed [SUM_BITS-1:0]  r_rd;
    logic                        r_rd_vld;
    logic signed [SUM_BITS-1:0]  old_sum;
    logic [IDX_BITS-1:0]         addr;
    t_wb                         wb;
    logic                        issue, div_start, div_done;
    logic [OUT_BITS-1:0]         div_quot;
    logic                        accept, out_fire, pair_end, row_end;
    logic [AX_BITS-1:0]          r_o_row, r_o_col;
    logic [OUT_BITS-1:0]         r_o_val;
    logic                        r_o_zw, r_o_last;

    // Axis count clamped to 1..MAX_AXES.
    always_comb begin
        if (r_axis_count == '0) begin
            eff_n = AX_BITS'(1);
        end else if (r_axis_count > AX_BITS'(MAX_AXES)) begin
            eff_n = AX_BITS'(MAX_AXES);
        end else begin
            eff_n = r_axis_count;
        end
    end

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;
    assign row_end  = (r_k == r_n - 1'b1);
    assign pair_end = row_end && (r_j == r_n - 1'b1);
    assign addr     = pair_idx(r_j, r_k);
    assign old_sum  = r_rd_vld ? r_rd : '0;
    assign wt_sum   = {1'b0, r_wt} + (WT_BITS+1)'(s_axis_tdata[WEIGHT_BITS-1:0]);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_count <= AX_BITS'(MAX_AXES);
            for (int i = 0; i < MAX_AXES; i++) begin
                r_mean[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_AXIS_COUNT) begin
                r_axis_count <= i_cfg_data[AX_BITS-1:0];
            end
            for (int i = 0; i < MAX_AXES; i++) begin
                if (i_cfg_idx == CFG_MEAN_BASE + CFG_IDX_BITS'(i)) begin
                    r_mean[i] <= i_cfg_data;
                end
            end
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept) n_state = ST_MAC;
            ST_MAC:   if (pair_end) n_state = ST_DRAIN;
            ST_DRAIN: if (r_dcnt == 2'd3) n_state = r_last ? ST_DRD : ST_IDLE;
            ST_DRD:   n_state = ST_DLD;
            ST_DLD:   n_state = (r_wt == '0) ? ST_OUT : ST_DRUN;
            ST_DRUN:  if (div_done) n_state = ST_OUT;
            ST_OUT:   if (out_fire) n_state = r_o_last ? ST_CLR : ST_DRD;
            ST_CLR:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Output decode of the sequencer.
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        issue         = 1'b0;
        div_start     = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_MAC:  issue = 1'b1;
            ST_DLD:  div_start = (r_wt != '0);
            ST_OUT:  m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    // Sequencer registers, hit capture and pair counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wt    <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_dcnt  <= '0;
            r_last  <= 1'b0;
            r_n     <= AX_BITS'(1);
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_wt   <= wt_sum[WT_BITS] ? WT_MAX : wt_sum[WT_BITS-1:0];
                r_last <= s_axis_tlast;
                r_n    <= eff_n;
                r_j    <= '0;
                r_k    <= '0;
                r_dcnt <= '0;
            end
            if (issue || (r_state == ST_OUT && out_fire)) begin
                if (row_end) begin
                    r_k <= '0;
                    r_j <= pair_end ? '0 : r_j + 1'b1;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            if (r_state == ST_DRAIN) begin
                r_dcnt <= r_dcnt + 1'b1;
            end
            if (r_state == ST_CLR) begin
                r_wt <= '0;
            end
        end
    end

    // Centered coordinates; the rotating copy feeds the column operand.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_w <= s_axis_tdata[WEIGHT_BITS-1:0];
            for (int i = 0; i < MAX_AXES; i++) begin
                r_d[i] <= DIFF_BITS'(signed'(s_axis_tdata[WEIGHT_BITS + i*COORD_BITS +:
                          COORD_BITS])) - DIFF_BITS'(r_mean[i]);
                r_rot[i] <= DIFF_BITS'(signed'(s_axis_tdata[WEIGHT_BITS + i*COORD_BITS +:
                          COORD_BITS])) - DIFF_BITS'(r_mean[i]);
            end
        end else if (issue) begin
            for (int i = 0; i < MAX_AXES; i++) begin
                if (row_end) begin
                    r_rot[i] <= r_d[i];
                end else begin
                    r_rot[i] <= r_rot[(i + 1) % MAX_AXES];
                end
            end
        end
    end

    // Pair-sum store; an entry without its valid bit reads as zero.
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[addr];
        if (wb.vld) begin
            r_mem[wb.idx] <= wb.sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[addr];
            if (r_state == ST_CLR) begin
                r_vld <= '0;
            end else if (wb.vld) begin
                r_vld[wb.idx] <= 1'b1;
            end
        end
    end

    wcm_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_issue  (issue),
        .i_idx    (addr),
        .i_dj     (r_d[r_j]),
        .i_dk     (r_rot[0]),
        .i_weight (r_w),
        .i_old    (old_sum),
        .o_wb     (wb)
    );

    wcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (old_sum),
        .i_den   (r_wt),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DLD) begin
            r_o_row  <= r_j;
            r_o_col  <= r_k;
            r_o_zw   <= (r_wt == '0);
            r_o_val  <= '0;
            r_o_last <= pair_end;
        end else if (r_state == ST_DRUN && div_done) begin
            r_o_val <= div_quot;
        end
    end

    assign m_axis_tdata = {2'b00, r_o_val, r_o_col, r_o_row};
    assign m_axis_tuser = r_o_zw;
    assign m_axis_tlast = r_o_last;

endmodule
